FILE: rtl/frb_pkg.sv
// Shared types, constants and helpers of the formant resonator bank.
package frb_pkg;

    // Defaults of the top-level parameters.
    localparam int DEF_BANK_SIZE    = 4;
    localparam int DEF_SAMPLE_BITS  = 24;
    localparam int DEF_COEFF_BITS   = 32;

    // Formant indexes travel on a fixed bus sized for the largest bank.
    localparam int MAX_FORMANTS = 8;
    localparam int FIDX_BITS    = $clog2(MAX_FORMANTS);

    // Configuration port.
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int NUM_COEFF_REGS = 4;
    localparam int A1_LSB         = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FORMANT0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FORMANT1 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FORMANT2 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FORMANT3 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIX      = 3'd4;

    // Mix level, Q0.16 with one integer bit so that 1.0 fits.
    localparam int MIX_BITS  = 17;
    localparam int MIX_ONE   = 65536;
    localparam int MIX_SHIFT = 16;

    // Resonator outputs are held as signed 32-bit words.
    localparam int Y_BITS = 32;

    // Output weights 1 - 0.15*f in units of 2^-16, signed (f can reach 7).
    localparam int WEIGHT_BITS = 18;
    localparam int WEIGHT_ONE  = 65536;
    localparam int WEIGHT_STEP = 9830;
    // 16 weight fraction bits plus the halving of the sum.
    localparam int SUM_SHIFT   = 17;

    typedef enum logic [2:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_SUB,
        MAC_HALF_ADD,
        MAC_ADD
    } mac_op_t;

    typedef enum logic [2:0] {
        A_GAIN,
        A_A1,
        A_WEIGHT,
        A_DRY,
        A_WET
    } a_sel_t;

    typedef enum logic [2:0] {
        B_DIFF,
        B_Y1,
        B_Y2,
        B_YRES,
        B_X,
        B_WETSUM
    } b_sel_t;

    // Controller to datapath command word.
    typedef struct packed {
        logic                 load;    // request taken: latch sample, update input delays
        mac_op_t              mac_op;  // accumulator operation
        a_sel_t               a_sel;   // multiplier coefficient operand
        b_sel_t               b_sel;   // multiplier data operand
        logic                 sum_en;  // add product into the weighted sum
        logic                 res_wr;  // finish resonator, shift its history
        logic                 out_ld;  // load the output register
        logic [FIDX_BITS-1:0] fidx;    // current formant
    } frb_cmd_t;

    function automatic logic signed [WEIGHT_BITS-1:0] formant_weight(
        input logic [FIDX_BITS-1:0] idx
    );
        formant_weight = WEIGHT_BITS'(WEIGHT_ONE - WEIGHT_STEP * int'(idx));
    endfunction

endpackage

FILE: rtl/frb_ctrl.sv
// Sequencer of the formant resonator bank: steps the shared MAC per sample.
module frb_ctrl #(
    parameter int BANK_SIZE = frb_pkg::DEF_BANK_SIZE
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output frb_pkg::frb_cmd_t cmd
);
    import frb_pkg::*;

    localparam int FIDX_W = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GDIFF,
        S_A1Y1,
        S_GY2,
        S_RES,
        S_WGT,
        S_DRY,
        S_WET,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [FIDX_W-1:0]   fidx_reg, fidx_next;
    logic                m_valid_reg, m_valid_next;
    logic                last_formant;
    logic                out_free;

    assign last_formant = (fidx_reg == FIDX_W'(BANK_SIZE - 1));
    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;

    always_comb begin
        state_next  = state_reg;
        fidx_next   = fidx_reg;
        cmd.load    = 1'b0;
        cmd.mac_op  = MAC_HOLD;
        cmd.a_sel   = A_GAIN;
        cmd.b_sel   = B_DIFF;
        cmd.sum_en  = 1'b0;
        cmd.res_wr  = 1'b0;
        cmd.out_ld  = 1'b0;
        cmd.fidx    = FIDX_BITS'(fidx_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    fidx_next  = '0;
                    state_next = S_GDIFF;
                end
            end
            S_GDIFF: begin
                cmd.mac_op = MAC_LOAD;
                cmd.a_sel  = A_GAIN;
                cmd.b_sel  = B_DIFF;
                state_next = S_A1Y1;
            end
            S_A1Y1: begin
                cmd.mac_op = MAC_SUB;
                cmd.a_sel  = A_A1;
                cmd.b_sel  = B_Y1;
                state_next = S_GY2;
            end
            S_GY2: begin
                cmd.mac_op = MAC_HALF_ADD;
                cmd.a_sel  = A_GAIN;
                cmd.b_sel  = B_Y2;
                state_next = S_RES;
            end
            S_RES: begin
                cmd.res_wr = 1'b1;
                state_next = S_WGT;
            end
            S_WGT: begin
                cmd.sum_en = 1'b1;
                cmd.a_sel  = A_WEIGHT;
                cmd.b_sel  = B_YRES;
                if (last_formant) begin
                    state_next = S_DRY;
                end else begin
                    fidx_next  = fidx_reg + FIDX_W'(1);
                    state_next = S_GDIFF;
                end
            end
            S_DRY: begin
                cmd.mac_op = MAC_LOAD;
                cmd.a_sel  = A_DRY;
                cmd.b_sel  = B_X;
                state_next = S_WET;
            end
            S_WET: begin
                cmd.mac_op = MAC_ADD;
                cmd.a_sel  = A_WET;
                cmd.b_sel  = B_WETSUM;
                state_next = S_OUT;
            end
            S_OUT: begin
                // wait here while an earlier result is still unclaimed
                if (out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fidx_reg    <= fidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/frb_dp.sv
// Datapath of the formant resonator bank: registers, history, shared MAC, output.
module frb_dp #(
    parameter int BANK_SIZE    = frb_pkg::DEF_BANK_SIZE,
    parameter int SAMPLE_BITS  = frb_pkg::DEF_SAMPLE_BITS,
    parameter int COEFF_BITS   = frb_pkg::DEF_COEFF_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [frb_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [frb_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample_in,
    input  logic                                   s_first_of_block,
    input  frb_pkg::frb_cmd_t                      cmd,
    output logic signed [SAMPLE_BITS-1:0]          m_sample_out,
    output logic                                   m_clipped
);
    import frb_pkg::*;

    localparam int FIDX_W = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    // weighted sum: y * weight, BANK_SIZE terms, one spare bit
    localparam int SUM_W  = Y_BITS + WEIGHT_BITS + $clog2(BANK_SIZE) + 1;
    localparam int WET_W  = SUM_W - SUM_SHIFT;
    // data operand: wet is the widest of diff, history, sample and wet
    localparam int A_W    = COEFF_BITS;
    localparam int B_W    = WET_W;
    localparam int P_W    = A_W + B_W;
    localparam int ACC_W  = P_W + 2;
    localparam int Y_SHIFT = COEFF_BITS - 3;

    // configuration
    logic signed [COEFF_BITS-1:0] gain_reg [NUM_COEFF_REGS];
    logic signed [COEFF_BITS-1:0] a1_reg   [NUM_COEFF_REGS];
    logic        [MIX_BITS-1:0]   mix_reg;

    // sample state
    logic signed [SAMPLE_BITS-1:0] x_reg, d1_reg, d2_reg;
    logic signed [DIFF_W-1:0]      diff_reg, diff_next;
    logic signed [Y_BITS-1:0]      y1_reg [BANK_SIZE];
    logic signed [Y_BITS-1:0]      y2_reg [BANK_SIZE];
    logic signed [Y_BITS-1:0]      yres_reg;

    // arithmetic
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [A_W-1:0]         a_op;
    logic signed [B_W-1:0]         b_op;
    logic signed [P_W-1:0]         prod;
    logic signed [ACC_W-1:0]       prod_ext;

    logic [FIDX_W-1:0]             fi;
    logic signed [COEFF_BITS-1:0]  gain_sel, a1_sel;
    logic signed [Y_BITS-1:0]      y1_sel, y2_sel;
    logic [MIX_BITS-1:0]           mix_eff;
    logic signed [WEIGHT_BITS-1:0] wet_fac, dry_fac;
    logic signed [WET_W-1:0]       wet;

    logic signed [ACC_W-1:0]       y_shift, y_diff;
    logic [ACC_W-Y_BITS:0]         y_top;
    logic signed [Y_BITS-1:0]      y_clamp;

    logic signed [ACC_W-1:0]       mixed;
    logic [ACC_W-SAMPLE_BITS:0]    mix_top;
    logic                          mix_fits;
    logic signed [SAMPLE_BITS-1:0] mix_clamp;

    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_clip_reg;

    assign fi = cmd.fidx[FIDX_W-1:0];

    // formants beyond the register file run with zero coefficients
    always_comb begin
        if (cmd.fidx < FIDX_BITS'(NUM_COEFF_REGS)) begin
            gain_sel = gain_reg[cmd.fidx[1:0]];
            a1_sel   = a1_reg[cmd.fidx[1:0]];
        end else begin
            gain_sel = '0;
            a1_sel   = '0;
        end
    end

    assign y1_sel  = y1_reg[fi];
    assign y2_sel  = y2_reg[fi];
    assign mix_eff = (mix_reg > MIX_BITS'(MIX_ONE)) ? MIX_BITS'(MIX_ONE) : mix_reg;
    assign wet_fac = $signed({1'b0, mix_eff});
    assign dry_fac = WEIGHT_BITS'(MIX_ONE) - wet_fac;
    // floor(sum / 2^17): the upper bits of the sum
    assign wet     = $signed(sum_reg[SUM_W-1:SUM_SHIFT]);

    always_comb begin
        case (cmd.a_sel)
            A_GAIN:   a_op = gain_sel;
            A_A1:     a_op = a1_sel;
            A_WEIGHT: a_op = A_W'(formant_weight(cmd.fidx));
            A_DRY:    a_op = A_W'(dry_fac);
            A_WET:    a_op = A_W'(wet_fac);
            default:  a_op = '0;
        endcase
    end

    always_comb begin
        case (cmd.b_sel)
            B_DIFF:   b_op = B_W'(diff_reg);
            B_Y1:     b_op = B_W'(y1_sel);
            B_Y2:     b_op = B_W'(y2_sel);
            B_YRES:   b_op = B_W'(yres_reg);
            B_X:      b_op = B_W'(x_reg);
            B_WETSUM: b_op = wet;
            default:  b_op = '0;
        endcase
    end

    assign prod     = a_op * b_op;
    assign prod_ext = ACC_W'(prod);

    always_comb begin
        case (cmd.mac_op)
            MAC_LOAD:     acc_next = prod_ext;
            MAC_SUB:      acc_next = acc_reg - prod_ext;
            MAC_HALF_ADD: acc_next = (acc_reg >>> 1) + prod_ext;
            MAC_ADD:      acc_next = acc_reg + prod_ext;
            default:      acc_next = acc_reg;
        endcase
    end

    always_comb begin
        sum_next = sum_reg;
        if (cmd.load) begin
            sum_next = '0;
        end else if (cmd.sum_en) begin
            sum_next = sum_reg + SUM_W'(prod);
        end
    end

    // resonator result: floor(t / 2^(COEFF_BITS-3)) - y2, saturated to 32 bits
    assign y_shift = acc_reg >>> Y_SHIFT;
    assign y_diff  = y_shift - ACC_W'(y2_sel);
    assign y_top   = y_diff[ACC_W-1:Y_BITS-1];
    always_comb begin
        if ((&y_top) || !(|y_top)) begin
            y_clamp = y_diff[Y_BITS-1:0];
        end else if (y_diff[ACC_W-1]) begin
            y_clamp = {1'b1, {(Y_BITS-1){1'b0}}};
        end else begin
            y_clamp = {1'b0, {(Y_BITS-1){1'b1}}};
        end
    end

    // final mix: floor(acc / 2^16), saturated to the sample width
    assign mixed    = acc_reg >>> MIX_SHIFT;
    assign mix_top  = mixed[ACC_W-1:SAMPLE_BITS-1];
    assign mix_fits = (&mix_top) || !(|mix_top);
    always_comb begin
        if (mix_fits) begin
            mix_clamp = mixed[SAMPLE_BITS-1:0];
        end else if (mixed[ACC_W-1]) begin
            mix_clamp = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            mix_clamp = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // a request that starts a block sees cleared input history
    assign diff_next = DIFF_W'(s_sample_in) - (s_first_of_block ? '0 : DIFF_W'(d2_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEFF_REGS; i++) begin
                gain_reg[i] <= '0;
                a1_reg[i]   <= '0;
            end
            mix_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index) inside
                REG_FORMANT0, REG_FORMANT1, REG_FORMANT2, REG_FORMANT3: begin
                    gain_reg[cfg_index[1:0]] <= cfg_wdata[COEFF_BITS-1:0];
                    a1_reg[cfg_index[1:0]]   <= cfg_wdata[A1_LSB +: COEFF_BITS];
                end
                REG_MIX: begin
                    mix_reg <= cfg_wdata[MIX_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
            for (int i = 0; i < BANK_SIZE; i++) begin
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end else if (cmd.load) begin
            d1_reg <= s_sample_in;
            d2_reg <= s_first_of_block ? '0 : d1_reg;
            if (s_first_of_block) begin
                for (int i = 0; i < BANK_SIZE; i++) begin
                    y1_reg[i] <= '0;
                    y2_reg[i] <= '0;
                end
            end
        end else if (cmd.res_wr) begin
            y2_reg[fi] <= y1_sel;
            y1_reg[fi] <= y_clamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= s_sample_in;
            diff_reg <= diff_next;
        end
        if (cmd.res_wr) begin
            yres_reg <= y_clamp;
        end
        if (cmd.out_ld) begin
            out_sample_reg <= mix_clamp;
            out_clip_reg   <= !mix_fits;
        end
        acc_reg <= acc_next;
        sum_reg <= sum_next;
    end

    assign m_sample_out = out_sample_reg;
    assign m_clipped    = out_clip_reg;

endmodule

FILE: rtl/formant_resonator_bank.sv
// Top level of the formant resonator bank: controller, datapath and checks.
//
// Formant resonator bank. Each signed sample request on the s_ channel runs
// through BANK_SIZE parallel band-pass biquads (direct form I, one shared
// pair of input delays, a pair of output delays per resonator). Resonator f
// uses gain g and feedback a1 from register formant<f>_coeffs (a1 in bits
// 63..32, g in bits 31..0, low COEFF_BITS of each used, Q2.(COEFF_BITS-2));
// its output saturates to 32 bits and is weighted 1 - 0.15*f. The weighted
// sum is halved, mixed with the dry sample by mix_level (Q0.16, values above
// 65536 count as 65536), floored, saturated to SAMPLE_BITS and returned on
// the m_ channel with m_clipped set when saturation hit. first_of_block
// clears all filter history before its own sample; registers are kept.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata);
// indexes above mix_level are ignored, and writes belong in idle time.
// Sequence: a sample runs through the single shared multiply-accumulate
// unit, and a new request is taken once the previous one has reached the
// output register. Per resonator the unit forms three products for the
// recursion, a step to round and saturate and one product for its weight,
// then two products for the mix and a step to saturate into the output
// register.
// The output register lets the next sample start while a result waits.
module formant_resonator_bank #(
    parameter int BANK_SIZE    = frb_pkg::DEF_BANK_SIZE,
    parameter int SAMPLE_BITS  = frb_pkg::DEF_SAMPLE_BITS,
    parameter int COEFF_BITS   = frb_pkg::DEF_COEFF_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [frb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [frb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // sample requests in
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_in,
    input  logic                               s_first_of_block,
    // results out
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    output logic                               m_clipped
);
    import frb_pkg::*;

    frb_cmd_t cmd;

    frb_ctrl #(
        .BANK_SIZE (BANK_SIZE)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    frb_dp #(
        .BANK_SIZE    (BANK_SIZE),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COEFF_BITS   (COEFF_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_sample_in      (s_sample_in),
        .s_first_of_block (s_first_of_block),
        .cmd              (cmd),
        .m_sample_out     (m_sample_out),
        .m_clipped        (m_clipped)
    );

`ifndef SYNTHESIS
    // a result is never written over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> (!m_valid || m_ready))
        else $error("output register loaded while a result was pending");

    // one sample in flight: a taken request blocks the input next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while a sample was in work");

    // history updates and weighted-sum terms stay inside the bank
    a_fidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.res_wr || cmd.sum_en) |-> (int'(cmd.fidx) < BANK_SIZE))
        else $error("formant index beyond the bank");

    // a loaded result shows up as valid in the next cycle
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |=> m_valid)
        else $error("loaded result not presented");
`endif

endmodule
